// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the rasterizer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ALR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked assertion, checked during reset too.
`define ALR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ----- rtl/alr_pkg.sv -----
// ----------------------------------------------------------------------------
// alr_pkg
// Types and constants shared by the antialiased line rasterizer modules.
// ----------------------------------------------------------------------------
package alr_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 8;
  localparam int RGB_W      = 24;
  localparam int COV_W      = FRAC_BITS;
  localparam int PIX_W      = COORD_BITS + 1;
  localparam int MINOR_W    = COORD_BITS + FRAC_BITS + 2;
  localparam int SLOPE_W    = FRAC_BITS + 2;
  localparam int REM_W      = COORD_BITS + 1;
  localparam int QUO_W      = FRAC_BITS + 1;
  localparam int DIV_STEPS  = QUO_W;
  localparam int CNT_W      = $clog2(DIV_STEPS);
  localparam int SLOPE_ONE  = 1 << FRAC_BITS;
  localparam int FRAC_HALF  = 1 << (FRAC_BITS - 1);

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_STEP = 1'b1
  } alr_req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_DIV,
    S_FIN,
    S_PIX0,
    S_PIX1
  } alr_state_t;

  typedef struct packed {
    logic load;
    logic setup;
    logic div_step;
    logic div_first;
    logic div_fin;
    logic emit0;
    logic emit1;
  } alr_cmd_t;

  typedef struct packed {
    logic line_active;
    logic out_free;
  } alr_sts_t;

endpackage

// ----- rtl/alr_ctrl.sv -----
// ----------------------------------------------------------------------------
// alr_ctrl
// Sequencer: input handshake, line setup, slope divide steps, pixel emission.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module alr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_req_type,
  input  alr_pkg::alr_sts_t sts,
  output alr_pkg::alr_cmd_t cmd
);
  import alr_pkg::*;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

  alr_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             in_fire;
  alr_req_t         req;

  assign req     = alr_req_t'(in_req_type);
  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (req == REQ_LOAD) begin
            state_nxt = S_SETUP;
          end else if (sts.line_active) begin
            state_nxt = S_PIX0;
          end
        end
      end
      S_SETUP: begin
        state_nxt = S_DIV;
        cnt_nxt   = '0;
      end
      S_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        state_nxt = S_IDLE;
      end
      S_PIX0: begin
        if (sts.out_free) begin
          state_nxt = S_PIX1;
        end
      end
      S_PIX1: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid && (req == REQ_LOAD);
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
      end
      S_DIV: begin
        cmd.div_step  = 1'b1;
        cmd.div_first = (cnt_r == '0);
      end
      S_FIN: begin
        cmd.div_fin = 1'b1;
      end
      S_PIX0: begin
        cmd.emit0 = sts.out_free;
      end
      S_PIX1: begin
        cmd.emit1 = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  `ALR_ASSERT(a_div_len, (state_r == S_DIV && cnt_r == CNT_LAST) |=> (state_r == S_FIN),
              "divide did not finish after its last step")
  `ALR_ASSERT(a_idle_step, (in_fire && req == REQ_STEP && !sts.line_active) |=> (state_r == S_IDLE),
              "step without active line left idle")

endmodule

// ----- rtl/alr_dp.sv -----
// ----------------------------------------------------------------------------
// alr_dp
// Datapath: endpoint setup, restoring slope divider, column walk, output word.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module alr_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  alr_pkg::alr_cmd_t             cmd,
  output alr_pkg::alr_sts_t             sts,
  input  logic [alr_pkg::COORD_BITS-1:0] in_start_x,
  input  logic [alr_pkg::COORD_BITS-1:0] in_start_y,
  input  logic [alr_pkg::COORD_BITS-1:0] in_end_x,
  input  logic [alr_pkg::COORD_BITS-1:0] in_end_y,
  input  logic [alr_pkg::RGB_W-1:0]      in_line_rgb,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [alr_pkg::PIX_W-1:0]      out_pixel_x,
  output logic [alr_pkg::PIX_W-1:0]      out_pixel_y,
  output logic [alr_pkg::COV_W-1:0]      out_coverage,
  output logic [alr_pkg::RGB_W-1:0]      out_pixel_rgb,
  output logic                          out_visible,
  output logic                          out_line_done,
  output logic                          out_last
);
  import alr_pkg::*;

  // latched endpoints
  logic [COORD_BITS-1:0] ax_r, ay_r, bx_r, by_r;
  logic [RGB_W-1:0]      held_rgb_r;

  // line state
  logic [PIX_W-1:0]      col_pos_r;
  logic [COORD_BITS-1:0] col_end_r;
  logic [MINOR_W-1:0]    minor_r;
  logic signed [SLOPE_W-1:0] slope_r;
  logic                  steep_r;
  logic                  line_active_r;

  // divider
  logic [COORD_BITS-1:0] dx_r;
  logic [REM_W-1:0]      rem_r;
  logic [QUO_W-1:0]      quo_r;
  logic                  neg_r;
  logic                  zero_r;

  // output word
  logic                  out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]      out_x_r, out_y_r;
  logic [COV_W-1:0]      out_cov_r;
  logic [RGB_W-1:0]      out_rgb_r;
  logic                  out_done_r, out_last_r;

  // setup logic
  logic [COORD_BITS-1:0] dxa, dya, sx0, sy0, sx1, sy1, mx0, my0, mx1, my1, dmin;
  logic                  steep, swap;

  always_comb begin
    dxa   = (bx_r > ax_r) ? bx_r - ax_r : ax_r - bx_r;
    dya   = (by_r > ay_r) ? by_r - ay_r : ay_r - by_r;
    steep = dya > dxa;
    sx0   = steep ? ay_r : ax_r;
    sy0   = steep ? ax_r : ay_r;
    sx1   = steep ? by_r : bx_r;
    sy1   = steep ? bx_r : by_r;
    swap  = sx0 > sx1;
    mx0   = swap ? sx1 : sx0;
    my0   = swap ? sy1 : sy0;
    mx1   = swap ? sx0 : sx1;
    my1   = swap ? sy0 : sy1;
    dmin  = steep ? dxa : dya;
  end

  // divide step
  logic [REM_W-1:0]   trial;
  logic               ge;
  logic signed [SLOPE_W-1:0] qext;

  assign trial = cmd.div_first ? rem_r : {rem_r[REM_W-2:0], 1'b0};
  assign ge    = trial >= {1'b0, dx_r};
  assign qext  = SLOPE_W'(quo_r);

  // current column
  logic [PIX_W-1:0] pix_a, pix_b, maj;
  logic [COV_W-1:0] frac;
  logic             done;
  logic [MINOR_W-1:0] slope_ext;

  assign pix_a     = minor_r[FRAC_BITS +: PIX_W];
  assign pix_b     = pix_a + 1'b1;
  assign frac      = minor_r[FRAC_BITS-1:0];
  assign maj       = col_pos_r;
  assign done      = col_pos_r >= {1'b0, col_end_r};
  assign slope_ext = {{(MINOR_W-SLOPE_W){slope_r[SLOPE_W-1]}}, slope_r};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ax_r       <= in_start_x;
      ay_r       <= in_start_y;
      bx_r       <= in_end_x;
      by_r       <= in_end_y;
      held_rgb_r <= in_line_rgb;
    end
    if (cmd.setup) begin
      steep_r   <= steep;
      col_pos_r <= {1'b0, mx0};
      col_end_r <= mx1;
      minor_r   <= (MINOR_W'(my0) << FRAC_BITS) | MINOR_W'(FRAC_HALF);
      dx_r      <= mx1 - mx0;
      rem_r     <= {1'b0, dmin};
      quo_r     <= '0;
      neg_r     <= my1 < my0;
      zero_r    <= (mx1 == mx0);
    end
    if (cmd.div_step) begin
      rem_r <= ge ? trial - {1'b0, dx_r} : trial;
      quo_r <= {quo_r[QUO_W-2:0], ge};
    end
    if (cmd.div_fin) begin
      slope_r <= zero_r ? SLOPE_W'(SLOPE_ONE) : (neg_r ? -qext : qext);
    end
    if (cmd.emit1) begin
      minor_r   <= minor_r + slope_ext;
      col_pos_r <= col_pos_r + 1'b1;
    end
    if (cmd.emit0 || cmd.emit1) begin
      out_x_r    <= steep_r ? (cmd.emit1 ? pix_b : pix_a) : maj;
      out_y_r    <= steep_r ? maj : (cmd.emit1 ? pix_b : pix_a);
      out_cov_r  <= cmd.emit1 ? frac : ~frac;
      out_rgb_r  <= held_rgb_r;
      out_done_r <= done;
      out_last_r <= cmd.emit1;
    end
  end

  // control state
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit0 || cmd.emit1) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r   <= 1'b0;
      line_active_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cmd.setup) begin
        line_active_r <= 1'b1;
      end else if (cmd.emit1 && done) begin
        line_active_r <= 1'b0;
      end
    end
  end

  assign sts.line_active = line_active_r;
  assign sts.out_free    = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_pixel_x   = out_x_r;
  assign out_pixel_y   = out_y_r;
  assign out_coverage  = out_cov_r;
  assign out_pixel_rgb = out_rgb_r;
  assign out_visible   = out_cov_r != '0;
  assign out_line_done = out_done_r;
  assign out_last      = out_last_r;

  `ALR_ASSERT(a_slope_rng, cmd.div_fin |=> (slope_r <= SLOPE_ONE && slope_r >= -SLOPE_ONE),
              "slope outside one pixel per column")
  `ALR_ASSERT(a_order, cmd.setup |=> (col_pos_r <= {1'b0, col_end_r}),
              "endpoints not ordered after setup")
  `ALR_ASSERT(a_second, cmd.emit1 |=> (out_valid_r && out_last_r),
              "second pixel not presented with last")

endmodule

// ----- rtl/antialiased_line_rasterizer.sv -----
// ----------------------------------------------------------------------------
// antialiased_line_rasterizer
// Wu-style antialiased line rasterizer, 14.8 fixed point, top level.
// ----------------------------------------------------------------------------
// A load word (req_type 0) latches two endpoints and a color and emits nothing;
// once accepted, it holds off input while a setup step swaps axes for steep
// lines and orders the endpoints, a restoring divider forms the slope
// dy*256/dx one quotient bit per cycle, and a final step applies the
// sign. A step word (req_type 1) emits the two pixels of the current column
// (coverage 255-frac, then frac, the second marked by last) and advances one
// column; once accepted, it sends each pixel in turn through the single
// output register, waiting while that register is full and not taken. The
// output register holds the second pixel while the next word is accepted.
// A step with no active line is taken and emits nothing. line_done marks both
// pixels of the final column; a load replaces any line in progress.
`include "assert_macros.svh"

module antialiased_line_rasterizer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_req_type,
  input  logic [alr_pkg::COORD_BITS-1:0] in_start_x,
  input  logic [alr_pkg::COORD_BITS-1:0] in_start_y,
  input  logic [alr_pkg::COORD_BITS-1:0] in_end_x,
  input  logic [alr_pkg::COORD_BITS-1:0] in_end_y,
  input  logic [alr_pkg::RGB_W-1:0]      in_line_rgb,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [alr_pkg::PIX_W-1:0]      out_pixel_x,
  output logic [alr_pkg::PIX_W-1:0]      out_pixel_y,
  output logic [alr_pkg::COV_W-1:0]      out_coverage,
  output logic [alr_pkg::RGB_W-1:0]      out_pixel_rgb,
  output logic                           out_visible,
  output logic                           out_line_done,
  output logic                           out_last
);
  import alr_pkg::*;

  alr_cmd_t cmd;
  alr_sts_t sts;

  // sequencer: accepts words, walks setup, divide and pixel emission
  alr_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .sts         (sts),
    .cmd         (cmd)
  );

  // datapath: endpoint registers, divider, column state, output register
  alr_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_start_x    (in_start_x),
    .in_start_y    (in_start_y),
    .in_end_x      (in_end_x),
    .in_end_y      (in_end_y),
    .in_line_rgb   (in_line_rgb),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pixel_x   (out_pixel_x),
    .out_pixel_y   (out_pixel_y),
    .out_coverage  (out_coverage),
    .out_pixel_rgb (out_pixel_rgb),
    .out_visible   (out_visible),
    .out_line_done (out_line_done),
    .out_last      (out_last)
  );

  // a load never overlaps pixel emission: the first pixel follows a step word
  `ALR_ASSERT(a_emit_src, cmd.emit0 |-> sts.line_active,
              "pixel emitted without an active line")

endmodule

// ----- tb/alr_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alr_checker
// Watches both channels of the line rasterizer, predicts the pixels of every
// accepted word from its own copy of the line state, and compares each pixel
// that leaves the block, field by field, with the oldest one predicted.
// ----------------------------------------------------------------------------
module alr_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic                           in_req_type,
  input  logic [alr_pkg::COORD_BITS-1:0] in_start_x,
  input  logic [alr_pkg::COORD_BITS-1:0] in_start_y,
  input  logic [alr_pkg::COORD_BITS-1:0] in_end_x,
  input  logic [alr_pkg::COORD_BITS-1:0] in_end_y,
  input  logic [alr_pkg::RGB_W-1:0]      in_line_rgb,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [alr_pkg::PIX_W-1:0]      out_pixel_x,
  input  logic [alr_pkg::PIX_W-1:0]      out_pixel_y,
  input  logic [alr_pkg::COV_W-1:0]      out_coverage,
  input  logic [alr_pkg::RGB_W-1:0]      out_pixel_rgb,
  input  logic                           out_visible,
  input  logic                           out_line_done,
  input  logic                           out_last,
  output int                             fail_count,
  output int                             pixels_pending
);
  import alr_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] y;
    logic [COV_W-1:0] cov;
    logic [RGB_W-1:0] rgb;
    logic             vis;
    logic             done;
    logic             last;
  } pixel_t;

  // Line state of the predictor
  logic [PIX_W-1:0]          col_pos;
  logic [COORD_BITS-1:0]     col_end;
  logic [MINOR_W-1:0]        minor_acc;
  logic signed [SLOPE_W-1:0] slope_fx;
  logic                      steep;
  logic                      active;
  logic [RGB_W-1:0]          rgb_hold;

  pixel_t pixel_queue[$];
  int     errors = 0;

  function automatic pixel_t make_pixel(input logic [PIX_W-1:0] major,
                                        input logic [MINOR_W-FRAC_BITS-1:0] row,
                                        input logic [COV_W-1:0] cov,
                                        input logic done, input logic second);
    pixel_t p;
    p.x    = steep ? row[PIX_W-1:0] : major;
    p.y    = steep ? major : row[PIX_W-1:0];
    p.cov  = cov;
    p.rgb  = rgb_hold;
    p.vis  = (cov != '0);
    p.done = done;
    p.last = second;
    return p;
  endfunction

  // Swap axes for steep lines, order the ends, form the slope by division.
  task automatic latch_line(input int sx, input int sy, input int ex, input int ey,
                            input logic [RGB_W-1:0] rgb);
    int ax, ay, bx, by, tmp, run, rise;
    ax   = sx;
    ay   = sy;
    bx   = ex;
    by   = ey;
    run  = (bx > ax) ? bx - ax : ax - bx;
    rise = (by > ay) ? by - ay : ay - by;
    steep = (rise > run);
    if (steep) begin
      tmp = ax; ax = ay; ay = tmp;
      tmp = bx; bx = by; by = tmp;
    end
    if (ax > bx) begin
      tmp = ax; ax = bx; bx = tmp;
      tmp = ay; ay = by; by = tmp;
    end
    run = bx - ax;
    // SystemVerilog integer division truncates toward zero
    if (run == 0) slope_fx = SLOPE_W'(SLOPE_ONE);
    else slope_fx = SLOPE_W'(((by - ay) * SLOPE_ONE) / run);
    minor_acc = MINOR_W'((ay << FRAC_BITS) + FRAC_HALF);
    col_pos   = PIX_W'(ax);
    col_end   = COORD_BITS'(bx);
    rgb_hold  = rgb;
    active    = 1'b1;
  endtask

  // Predict the two pixels of the current column, then advance one column.
  task automatic emit_column();
    logic [MINOR_W-FRAC_BITS-1:0] row;
    logic [FRAC_BITS-1:0]         frac;
    logic                         done;
    if (!active) return;
    row  = minor_acc[MINOR_W-1:FRAC_BITS];
    frac = minor_acc[FRAC_BITS-1:0];
    done = (col_pos >= PIX_W'(col_end));
    pixel_queue.push_back(make_pixel(col_pos, row, ~frac, done, 1'b0));
    pixel_queue.push_back(make_pixel(col_pos, row + 1'b1, frac, done, 1'b1));
    minor_acc = minor_acc + {{(MINOR_W-SLOPE_W){slope_fx[SLOPE_W-1]}}, slope_fx};
    col_pos   = col_pos + 1'b1;
    if (done) active = 1'b0;
  endtask

  task automatic field_check(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  task automatic check_pixel();
    pixel_t want;
    if (pixel_queue.size() == 0) begin
      errors++;
      $display("%0t: unexpected pixel: expected none, got x=%0d y=%0d cov=%0d",
               $time, out_pixel_x, out_pixel_y, out_coverage);
    end else begin
      want = pixel_queue.pop_front();
      field_check("pixel_x", 32'(want.x), 32'(out_pixel_x));
      field_check("pixel_y", 32'(want.y), 32'(out_pixel_y));
      field_check("coverage", 32'(want.cov), 32'(out_coverage));
      field_check("pixel_rgb", 32'(want.rgb), 32'(out_pixel_rgb));
      field_check("visible", 32'(want.vis), 32'(out_visible));
      field_check("line_done", 32'(want.done), 32'(out_line_done));
      field_check("last", 32'(want.last), 32'(out_last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      col_pos   = '0;
      col_end   = '0;
      minor_acc = '0;
      slope_fx  = '0;
      steep     = 1'b0;
      active    = 1'b0;
      rgb_hold  = '0;
      pixel_queue.delete();
    end else begin
      if (out_valid && out_ready) check_pixel();
      if (in_valid && in_ready) begin
        if (in_req_type == REQ_STEP) emit_column();
        else latch_line(int'(in_start_x), int'(in_start_y), int'(in_end_x),
                        int'(in_end_y), in_line_rgb);
      end
    end
    fail_count     <= errors;
    pixels_pending <= pixel_queue.size();
  end

endmodule

// ----- tb/tb_antialiased_line_rasterizer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_antialiased_line_rasterizer
// Drives load and step words into the line rasterizer with random gaps and
// output stalls; a checker beside the block predicts and compares every pixel.
// ----------------------------------------------------------------------------
module tb_antialiased_line_rasterizer;
  import alr_pkg::*;

  // Cycles with no word moving on either channel before the run is called hung.
  // A load holds the input through setup and the divide; stalls are short random runs.
  localparam int STALL_LIMIT = 2000;
  localparam int ITEM_TARGET = 900;
  localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
  localparam int RGB_MAX     = (1 << RGB_W) - 1;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_req_type;
  logic [COORD_BITS-1:0] in_start_x;
  logic [COORD_BITS-1:0] in_start_y;
  logic [COORD_BITS-1:0] in_end_x;
  logic [COORD_BITS-1:0] in_end_y;
  logic [RGB_W-1:0]      in_line_rgb;
  logic                  out_valid;
  logic                  out_ready;
  logic [PIX_W-1:0]      out_pixel_x;
  logic [PIX_W-1:0]      out_pixel_y;
  logic [COV_W-1:0]      out_coverage;
  logic [RGB_W-1:0]      out_pixel_rgb;
  logic                  out_visible;
  logic                  out_line_done;
  logic                  out_last;

  int fail_count;
  int pixels_pending;
  int send_idle_pct = 22;
  int recv_idle_pct = 67;
  int useful_words  = 0;
  int idle_cycles   = 0;

  antialiased_line_rasterizer dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .in_start_x    (in_start_x),
    .in_start_y    (in_start_y),
    .in_end_x      (in_end_x),
    .in_end_y      (in_end_y),
    .in_line_rgb   (in_line_rgb),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pixel_x   (out_pixel_x),
    .out_pixel_y   (out_pixel_y),
    .out_coverage  (out_coverage),
    .out_pixel_rgb (out_pixel_rgb),
    .out_visible   (out_visible),
    .out_line_done (out_line_done),
    .out_last      (out_last)
  );

  alr_checker check_u (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_start_x     (in_start_x),
    .in_start_y     (in_start_y),
    .in_end_x       (in_end_x),
    .in_end_y       (in_end_y),
    .in_line_rgb    (in_line_rgb),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_coverage   (out_coverage),
    .out_pixel_rgb  (out_pixel_rgb),
    .out_visible    (out_visible),
    .out_line_done  (out_line_done),
    .out_last       (out_last),
    .fail_count     (fail_count),
    .pixels_pending (pixels_pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Pixel receiver: roll ready at every falling edge, so stalls land on either
  // pixel of a step and on the cycle the next word is taken.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Hang detector: count cycles in which no word moves on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= STALL_LIMIT) begin
      $display("tb_antialiased_line_rasterizer: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Number of columns a line covers: its longer extent plus one.
  function automatic int line_columns(input int sx, input int sy, input int ex,
                                      input int ey);
    int run, rise;
    run  = (ex > sx) ? ex - sx : sx - ex;
    rise = (ey > sy) ? ey - sy : sy - ey;
    return ((rise > run) ? rise : run) + 1;
  endfunction

  // Present one word from a falling edge and hold it until it is taken. Each
  // falling edge carries exactly one assignment to in_valid: either a gap
  // cycle (drop valid) or the word itself.
  task automatic send_word(input alr_req_t req, input logic [COORD_BITS-1:0] sx,
                           input logic [COORD_BITS-1:0] sy,
                           input logic [COORD_BITS-1:0] ex,
                           input logic [COORD_BITS-1:0] ey,
                           input logic [RGB_W-1:0] rgb);
    // first third: sender busy, receiver slow; then swapped; then flat out
    if (useful_words < ITEM_TARGET / 3) begin
      send_idle_pct = 22;
      recv_idle_pct = 67;
    end else if (useful_words < 2 * ITEM_TARGET / 3) begin
      send_idle_pct = 67;
      recv_idle_pct = 22;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_start_x  <= sx;
    in_start_y  <= sy;
    in_end_x    <= ex;
    in_end_y    <= ey;
    in_line_rgb <= rgb;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic load_line(input int sx, input int sy, input int ex, input int ey,
                           input logic [RGB_W-1:0] rgb);
    send_word(REQ_LOAD, COORD_BITS'(sx), COORD_BITS'(sy), COORD_BITS'(ex),
              COORD_BITS'(ey), rgb);
    useful_words++;
  endtask

  // Step words carry random coordinates and color; the block must ignore them.
  // Steps that hit no active line are not counted toward the item target.
  task automatic step_columns(input int n, input int counted);
    repeat (n) begin
      send_word(REQ_STEP, COORD_BITS'($urandom_range(COORD_MAX)),
                COORD_BITS'($urandom_range(COORD_MAX)),
                COORD_BITS'($urandom_range(COORD_MAX)),
                COORD_BITS'($urandom_range(COORD_MAX)),
                RGB_W'($urandom_range(RGB_MAX)));
      if (counted != 0) useful_words++;
    end
  endtask

  initial begin
    int roll, major, minor, dxv, dyv, tmp, cols;
    int sx, sy, ex, ey;

    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_req_type = REQ_LOAD;
    in_start_x  = '0;
    in_start_y  = '0;
    in_end_x    = '0;
    in_end_y    = '0;
    in_line_rgb = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // --- directed words ---
    // step before any line is loaded: taken, nothing comes out
    step_columns(1, 0);
    // single point at the far corner: coverage 127 there, 128 one row past it
    load_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 24'hFFFFFF);
    step_columns(1, 1);
    // the point is finished, so this step emits nothing
    step_columns(1, 0);
    // flat black line from the origin
    load_line(0, 0, 3, 0, 24'h000000);
    step_columns(4, 1);
    // steep line given right to left: axes swap and the ends reorder
    load_line(2, 5, 0, 0, 24'hA5C35A);
    step_columns(line_columns(2, 5, 0, 0), 1);
    // 45 degrees falling at the right edge: slope of minus one
    load_line(COORD_MAX, 0, COORD_MAX - 3, 3, 24'h5A3CA5);
    step_columns(4, 1);
    // screen-wide diagonal, cut short by a new load while still active
    load_line(0, COORD_MAX, COORD_MAX, 0, 24'h123456);
    step_columns(2, 1);
    load_line(1, 1, 2, 1, 24'h876543);
    step_columns(2, 1);

    // --- random lines ---
    // Mostly whole lines stepped to their end; some abandoned midway so the
    // next load replaces them; a few stray steps with or without a line open.
    while (useful_words < ITEM_TARGET) begin
      roll = $urandom_range(99);
      if (roll < 90) begin
        // short lines mostly, a few longer ones
        major = ($urandom_range(9) == 0) ? $urandom_range(150) : $urandom_range(12);
        minor = $urandom_range(major);
        dxv   = major;
        dyv   = minor;
        if ($urandom_range(1)) begin
          tmp = dxv; dxv = dyv; dyv = tmp;
        end
        if ($urandom_range(1)) dxv = -dxv;
        if ($urandom_range(1)) dyv = -dyv;
        sx = $urandom_range(COORD_MAX);
        sy = $urandom_range(COORD_MAX);
        // keep the far end on screen
        if (sx + dxv > COORD_MAX || sx + dxv < 0) dxv = -dxv;
        if (sy + dyv > COORD_MAX || sy + dyv < 0) dyv = -dyv;
        ex = sx + dxv;
        ey = sy + dyv;
        cols = line_columns(sx, sy, ex, ey);
        load_line(sx, sy, ex, ey, RGB_W'($urandom_range(RGB_MAX)));
        if (roll < 80) begin
          step_columns(cols, 1);
          // now and then, a step past the end of the line
          if ($urandom_range(9) == 0) step_columns(1, 0);
        end else begin
          step_columns($urandom_range(cols - 1), 1);
        end
      end else begin
        step_columns($urandom_range(3, 1), 0);
      end
    end

    // Drop valid, drain every expected pixel, then let the block settle.
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pixels_pending == 0);
    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_antialiased_line_rasterizer: done, clean");
    end else begin
      $display("tb_antialiased_line_rasterizer: done, errors");
    end
    $finish;
  end

endmodule
